FILE: hdl/opaf_pkg.sv
// Shared types, constants and helpers of the one-pole audio filter.
`timescale 1ns / 1ps

package opaf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W = 16;
   localparam int MODE_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_INDEX_W = 2;

   localparam logic [MODE_W-1:0] MODE_LOWPASS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   localparam logic [REG_INDEX_W-1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_LOWPASS_COEFF = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_HIGHPASS_COEFF = 2'd2;

   localparam logic [MODE_W-1:0] RESET_FILTER_MODE = MODE_LOWPASS;
   localparam logic [COEFF_W-1:0] RESET_LOWPASS_COEFF = 16'h8000;
   localparam logic [COEFF_W-1:0] RESET_HIGHPASS_COEFF = 16'hFFFF;

   typedef struct packed {
      logic capture;
      logic mul_en;
      logic mul_sel_lp;
      logic hp_fin;
      logic lp_fin;
      logic load_out;
      logic out_sel_lp;
   } cmd_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
      logic signed [SAMPLE_W-1:0] r;
      r = v[SAMPLE_W-1:0];
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end
      return r;
   endfunction

endpackage

FILE: hdl/opaf_csr.sv
// Configuration registers of the filter behind an APB-style port.
`timescale 1ns / 1ps

module opaf_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [opaf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [opaf_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [opaf_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready,
   output logic [opaf_pkg::MODE_W-1:0]            filter_mode,
   output logic [opaf_pkg::COEFF_W-1:0]           lowpass_coeff,
   output logic [opaf_pkg::COEFF_W-1:0]           highpass_coeff
);

   logic [opaf_pkg::MODE_W-1:0] mode_ff;
   logic [opaf_pkg::COEFF_W-1:0] lp_coeff_ff;
   logic [opaf_pkg::COEFF_W-1:0] hp_coeff_ff;
   logic [opaf_pkg::REG_INDEX_W-1:0] reg_index;
   logic wr_en;

   assign pready = 1'b1;
   assign reg_index = paddr[opaf_pkg::CSR_ADDR_W-1:2];
   assign wr_en = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= opaf_pkg::RESET_FILTER_MODE;
         lp_coeff_ff <= opaf_pkg::RESET_LOWPASS_COEFF;
         hp_coeff_ff <= opaf_pkg::RESET_HIGHPASS_COEFF;
      end else if (wr_en) begin
         case (reg_index)
            opaf_pkg::REG_FILTER_MODE: begin
               mode_ff <= pwdata[opaf_pkg::MODE_W-1:0];
            end
            opaf_pkg::REG_LOWPASS_COEFF: begin
               lp_coeff_ff <= pwdata[opaf_pkg::COEFF_W-1:0];
            end
            opaf_pkg::REG_HIGHPASS_COEFF: begin
               hp_coeff_ff <= pwdata[opaf_pkg::COEFF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         opaf_pkg::REG_FILTER_MODE: begin
            prdata = {{(opaf_pkg::CSR_DATA_W-opaf_pkg::MODE_W){1'b0}}, mode_ff};
         end
         opaf_pkg::REG_LOWPASS_COEFF: begin
            prdata = {{(opaf_pkg::CSR_DATA_W-opaf_pkg::COEFF_W){1'b0}}, lp_coeff_ff};
         end
         opaf_pkg::REG_HIGHPASS_COEFF: begin
            prdata = {{(opaf_pkg::CSR_DATA_W-opaf_pkg::COEFF_W){1'b0}}, hp_coeff_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign filter_mode = mode_ff;
   assign lowpass_coeff = lp_coeff_ff;
   assign highpass_coeff = hp_coeff_ff;

endmodule

FILE: hdl/opaf_dp.sv
// Filter datapath: sample history, one shared multiplier and the result register.
`timescale 1ns / 1ps

module opaf_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  opaf_pkg::cmd_type                      cmd,
   input  logic signed [opaf_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                   req_buffer_start,
   input  logic [opaf_pkg::COEFF_W-1:0]           lowpass_coeff,
   input  logic [opaf_pkg::COEFF_W-1:0]           highpass_coeff,
   output logic signed [opaf_pkg::SAMPLE_W-1:0]   rsp_sample_out
);

   logic signed [15:0] x_ff;
   logic start_ff;
   logic signed [15:0] lp_in_ff;
   logic signed [15:0] lp_in_in;
   logic signed [15:0] lp_last_ff;
   logic signed [15:0] hp_last_in_ff;
   logic signed [15:0] hp_last_out_ff;
   logic signed [34:0] prod_ff;
   logic signed [34:0] prod_in;
   logic signed [15:0] out_ff;

   logic signed [15:0] hp_prev_in;
   logic signed [15:0] hp_prev_out;
   logic signed [17:0] hp_acc;
   logic signed [17:0] lp_diff;
   logic signed [17:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [19:0] hp_shift;
   logic signed [19:0] lp_sum;
   logic signed [15:0] hp_y;
   logic signed [15:0] lp_y;

   assign hp_prev_in = start_ff ? 16'sd0 : hp_last_in_ff;
   assign hp_prev_out = start_ff ? 16'sd0 : hp_last_out_ff;
   assign hp_acc = {{2{hp_prev_out[15]}}, hp_prev_out} + {{2{x_ff[15]}}, x_ff}
                 - {{2{hp_prev_in[15]}}, hp_prev_in};
   assign lp_diff = {{2{lp_in_ff[15]}}, lp_in_ff} - {{2{lp_last_ff[15]}}, lp_last_ff};

   assign mul_a = cmd.mul_sel_lp ? lp_diff : hp_acc;
   assign mul_b = cmd.mul_sel_lp ? $signed({1'b0, lowpass_coeff})
                                 : $signed({1'b0, highpass_coeff});
   assign prod_in = mul_a * mul_b;

   assign hp_shift = {prod_ff[34], prod_ff[34:16]};
   assign hp_y = opaf_pkg::sat16(hp_shift);
   assign lp_sum = {{4{lp_last_ff[15]}}, lp_last_ff} + {prod_ff[34], prod_ff[34:16]};
   assign lp_y = start_ff ? lp_in_ff : opaf_pkg::sat16(lp_sum);

   always_comb begin
      lp_in_in = lp_in_ff;
      if (cmd.capture) begin
         lp_in_in = req_sample_in;
      end else if (cmd.hp_fin) begin
         lp_in_in = hp_y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_sample_in;
         start_ff <= req_buffer_start;
      end
      lp_in_ff <= lp_in_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_out) begin
         out_ff <= cmd.out_sel_lp ? lp_y : hp_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_last_ff <= '0;
         hp_last_in_ff <= '0;
         hp_last_out_ff <= '0;
      end else begin
         if (cmd.lp_fin) begin
            lp_last_ff <= lp_y;
         end
         if (cmd.hp_fin) begin
            hp_last_in_ff <= x_ff;
            hp_last_out_ff <= hp_y;
         end
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

FILE: hdl/opaf_ctrl.sv
// Sequencer of the filter: steps each beat through the highpass stage, the lowpass stage or both, by mode.
`timescale 1ns / 1ps

module opaf_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [opaf_pkg::MODE_W-1:0]  filter_mode,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output opaf_pkg::cmd_type            cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_HP_MUL = 5'b00010,
      ST_HP_FIN = 5'b00100,
      ST_LP_MUL = 5'b01000,
      ST_LP_FIN = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic use_hp;
   logic chain_lp;
   logic finishing;
   logic accept;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign use_hp = (filter_mode != opaf_pkg::MODE_LOWPASS);
   assign chain_lp = (filter_mode == opaf_pkg::MODE_BANDPASS)
                  || (filter_mode == opaf_pkg::MODE_RESERVED);
   assign finishing = out_free && ((state_ff == ST_LP_FIN)
                  || ((state_ff == ST_HP_FIN) && !chain_lp));
   assign req_ready = (state_ff == ST_IDLE) || finishing;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.capture = accept;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_HP_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = ST_HP_FIN;
         end
         ST_HP_FIN: begin
            if (chain_lp) begin
               cmd.hp_fin = 1'b1;
               state_in = ST_LP_MUL;
            end else if (out_free) begin
               cmd.hp_fin = 1'b1;
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LP_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel_lp = 1'b1;
            state_in = ST_LP_FIN;
         end
         ST_LP_FIN: begin
            cmd.mul_sel_lp = 1'b1;
            cmd.out_sel_lp = 1'b1;
            if (out_free) begin
               cmd.lp_fin = 1'b1;
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         state_in = use_hp ? ST_HP_MUL : ST_LP_MUL;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/one_pole_audio_filter.sv
// Top level of the one-pole audio filter: register port, sequencer and datapath.
`timescale 1ns / 1ps

// First-order RC filter on signed Q1.15 samples with lowpass, highpass and bandpass
// modes, programmed through registers at byte addresses 0x0 (mode), 0x4 (lowpass
// coefficient) and 0x8 (highpass coefficient, both unsigned Q0.16). Each stage runs
// on the single shared 18x17 multiplier in a multiply state and then a finish state
// (shift, add and saturate); bandpass mode runs the highpass stage and then the
// lowpass stage. The next sample is taken in the cycle that the current result is
// written to the output register, which holds it until the consumer takes the beat.

module one_pole_audio_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [opaf_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                   req_buffer_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [opaf_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [opaf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [opaf_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [opaf_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);

   logic [opaf_pkg::MODE_W-1:0] filter_mode;
   logic [opaf_pkg::COEFF_W-1:0] lowpass_coeff;
   logic [opaf_pkg::COEFF_W-1:0] highpass_coeff;
   opaf_pkg::cmd_type cmd;

   opaf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .filter_mode    (filter_mode),
      .lowpass_coeff  (lowpass_coeff),
      .highpass_coeff (highpass_coeff)
   );

   opaf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (filter_mode),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   opaf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample_in    (req_sample_in),
      .req_buffer_start (req_buffer_start),
      .lowpass_coeff    (lowpass_coeff),
      .highpass_coeff   (highpass_coeff),
      .rsp_sample_out   (rsp_sample_out)
   );

   // A new result is never written over one the consumer has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while a beat was pending");

   // A result is waiting once a lowpass beat has passed the lowpass multiply and finish states.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (filter_mode == opaf_pkg::MODE_LOWPASS))
         |=> ##2 rsp_valid)
      else $error("lowpass result late");

   // A bandpass beat blocks new input while its stages run.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (filter_mode == opaf_pkg::MODE_BANDPASS))
         |=> !req_ready)
      else $error("input taken during bandpass processing");

endmodule

FILE: test/opaf_response_check.sv
// Checker for the one-pole audio filter: tracks the registers, predicts each output sample and compares.
`timescale 1ns / 1ps

module opaf_response_check (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [opaf_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                   req_buffer_start,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [opaf_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [opaf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [opaf_pkg::CSR_DATA_W-1:0]        pwdata,
   input  logic                                   pready,
   output int                                     fail_count,
   output int                                     pending
);

   logic [opaf_pkg::MODE_W-1:0] mode;
   logic [opaf_pkg::COEFF_W-1:0] lp_coeff;
   logic [opaf_pkg::COEFF_W-1:0] hp_coeff;
   logic signed [opaf_pkg::SAMPLE_W-1:0] lp_out;
   logic signed [opaf_pkg::SAMPLE_W-1:0] hp_in;
   logic signed [opaf_pkg::SAMPLE_W-1:0] hp_out;
   logic signed [opaf_pkg::SAMPLE_W-1:0] expected_out[$];
   logic signed [opaf_pkg::SAMPLE_W-1:0] want;
   int errors;

   function automatic logic signed [15:0] clip_q15(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] lowpass_stage(logic signed [15:0] x, logic restart);
      longint step;
      if (restart) begin
         lp_out = x;
      end else begin
         step = (longint'(x) - longint'(lp_out)) * longint'(lp_coeff);
         lp_out = clip_q15(longint'(lp_out) + (step >>> 16));
      end
      return lp_out;
   endfunction

   function automatic logic signed [15:0] highpass_stage(logic signed [15:0] x, logic restart);
      longint acc;
      if (restart) begin
         hp_in = '0;
         hp_out = '0;
      end
      acc = longint'(hp_out) + longint'(x) - longint'(hp_in);
      hp_in = x;
      hp_out = clip_q15((acc * longint'(hp_coeff)) >>> 16);
      return hp_out;
   endfunction

   // Any mode other than lowpass or highpass runs both stages in series.
   function automatic logic signed [15:0] filter_sample(logic signed [15:0] x, logic restart);
      if (mode == opaf_pkg::MODE_LOWPASS) return lowpass_stage(x, restart);
      if (mode == opaf_pkg::MODE_HIGHPASS) return highpass_stage(x, restart);
      return lowpass_stage(highpass_stage(x, restart), restart);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode = opaf_pkg::RESET_FILTER_MODE;
         lp_coeff = opaf_pkg::RESET_LOWPASS_COEFF;
         hp_coeff = opaf_pkg::RESET_HIGHPASS_COEFF;
         lp_out = '0;
         hp_in = '0;
         hp_out = '0;
         expected_out.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[opaf_pkg::CSR_ADDR_W-1:2])
               opaf_pkg::REG_FILTER_MODE: mode = pwdata[opaf_pkg::MODE_W-1:0];
               opaf_pkg::REG_LOWPASS_COEFF: lp_coeff = pwdata[opaf_pkg::COEFF_W-1:0];
               opaf_pkg::REG_HIGHPASS_COEFF: hp_coeff = pwdata[opaf_pkg::COEFF_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               errors++;
               $error("sample_out: expected no beat, actual %0d", rsp_sample_out);
            end else begin
               want = expected_out.pop_front();
               if (want !== rsp_sample_out) begin
                  errors++;
                  $error("sample_out: expected %0d, actual %0d", want, rsp_sample_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_out.push_back(filter_sample(req_sample_in, req_buffer_start));
         end
      end
      fail_count <= errors;
      pending <= expected_out.size();
   end

endmodule

FILE: test/tb_one_pole_audio_filter.sv
// Testbench top for the one-pole audio filter: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_one_pole_audio_filter;

   localparam logic [opaf_pkg::REG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int MAX_IDLE = 18;
   localparam int RANDOM_BEATS = 1600;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [opaf_pkg::SAMPLE_W-1:0] req_sample_in;
   logic req_buffer_start;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [opaf_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic psel;
   logic penable;
   logic pwrite;
   logic [opaf_pkg::CSR_ADDR_W-1:0] paddr;
   logic [opaf_pkg::CSR_DATA_W-1:0] pwdata;
   logic [opaf_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count;
   int pending;
   logic steady;
   int beats_sent;
   int buffer_left;
   int phase_len;

   one_pole_audio_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .req_buffer_start(req_buffer_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   opaf_response_check response_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .req_buffer_start(req_buffer_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .pready(pready),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("one_pole_audio_filter: mismatch");
      $finish;
   end

   function automatic int idle_cycles();
      return steady ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic logic [opaf_pkg::CSR_DATA_W-1:0] pick_coeff();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h0000_FFFF;
         2: return $urandom;
         default: return 32'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic signed [opaf_pkg::SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 600)) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [opaf_pkg::REG_INDEX_W-1:0] idx,
                            input logic [opaf_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [opaf_pkg::SAMPLE_W-1:0] s,
                              input logic start);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      req_buffer_start <= start;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Holds off the sender until every outstanding beat has been returned.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_buffer_start = 1'b0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady = 1'b0;
      beats_sent = 0;
      buffer_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Lowpass with the reset coefficients, full-scale steps.
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      drain();
      write_reg(opaf_pkg::REG_LOWPASS_COEFF, 32'h0000_FFFF);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      drain();
      // Upper data bits are dropped by the register width.
      write_reg(opaf_pkg::REG_LOWPASS_COEFF, {16'hABCD, 16'h0000});
      send_sample(16'sh3039, 1'b0);
      send_sample(16'shFFFF, 1'b1);
      send_sample(16'sh0005, 1'b0);
      drain();
      write_reg(opaf_pkg::REG_FILTER_MODE, 32'(opaf_pkg::MODE_HIGHPASS));
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      drain();
      write_reg(opaf_pkg::REG_HIGHPASS_COEFF, {16'hFFFF, 16'h0000});
      send_sample(16'sh03E8, 1'b0);
      send_sample(16'shFFFF, 1'b1);
      drain();
      // The unused mode code must behave as bandpass.
      write_reg(opaf_pkg::REG_FILTER_MODE, {30'h3FFF_FFFF, opaf_pkg::MODE_RESERVED});
      write_reg(opaf_pkg::REG_HIGHPASS_COEFF, 32'h0000_FFFF);
      write_reg(opaf_pkg::REG_LOWPASS_COEFF, 32'h0000_FFFF);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);
      drain();
      write_reg(opaf_pkg::REG_FILTER_MODE, 32'(opaf_pkg::MODE_BANDPASS));
      send_sample(16'sh0064, 1'b0);
      send_sample(16'shFF9C, 1'b0);
      drain();
      write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
      write_reg(opaf_pkg::REG_FILTER_MODE, 32'(opaf_pkg::MODE_LOWPASS));
      send_sample(16'sh0000, 1'b0);

      while (beats_sent < RANDOM_BEATS) begin
         drain();
         steady = 1'b0;
         if ($urandom_range(0, 2) != 0) begin
            write_reg(opaf_pkg::REG_FILTER_MODE, ($urandom_range(0, 3) == 0) ?
                      $urandom : 32'($urandom_range(0, 2)));
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(opaf_pkg::REG_LOWPASS_COEFF, pick_coeff());
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(opaf_pkg::REG_HIGHPASS_COEFF, pick_coeff());
         end
         steady = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(20, 120);
         repeat (phase_len) begin
            if (buffer_left == 0) begin
               buffer_left = $urandom_range(1, 40);
               send_sample(random_sample(), 1'b1);
            end else begin
               send_sample(random_sample(), $urandom_range(0, 30) == 0);
            end
            buffer_left--;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("one_pole_audio_filter: match");
      end else begin
         $display("one_pole_audio_filter: mismatch");
      end
      $finish;
   end

endmodule
